// File: src/lz78_pkg.sv
// Shared constants and types for the LZ78 factor encoder.
package lz78_pkg;

  localparam int SYM_W         = 8;
  localparam int PREFIX_W      = 10;
  localparam int DICT_SIZE_DEF = 1024;

  typedef struct packed {
    logic compare;
    logic write;
  } cell_cmd_t;

endpackage

// File: src/lz78_in_if.sv
// Input channel interface: one byte of the stream per transfer.
interface lz78_in_if
  import lz78_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] data_byte;
  logic             end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// File: src/lz78_out_if.sv
// Output channel interface: one emitted factor per transfer.
interface lz78_out_if
  import lz78_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SYM_W-1:0]    symbol;
  logic [PREFIX_W-1:0] prefix_index;
  logic                stream_done;

  modport source (output valid, output symbol, output prefix_index, output stream_done,
                  input ready);
  modport sink (input valid, input symbol, input prefix_index, input stream_done,
                output ready);
endinterface

// File: src/lz78_cell.sv
// One dictionary cell: stores a phrase entry, compares it with the key, chains the hit index.
module lz78_cell
  import lz78_pkg::*;
#(
  parameter int IDX_W   = 10,
  parameter int NF_W    = 11,
  parameter int CellIdx = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_cmd_t        cmd,
  input  logic [IDX_W-1:0] key_parent,
  input  logic [SYM_W-1:0] key_byte,
  input  logic [NF_W-1:0]  next_free,
  input  logic [IDX_W-1:0] hit_chain_in,
  output logic [IDX_W-1:0] hit_chain_out
);

  logic [IDX_W-1:0] parent;
  logic [SYM_W-1:0] entry_byte;
  logic             hit;
  logic             live;

  assign live = NF_W'(CellIdx) < next_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.compare) begin
      hit <= live && (parent == key_parent) && (entry_byte == key_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && (next_free == NF_W'(CellIdx))) begin
      parent     <= key_parent;
      entry_byte <= key_byte;
    end
  end

  assign hit_chain_out = hit_chain_in | (hit ? IDX_W'(CellIdx) : '0);

endmodule

// File: src/lz78_encoder.sv
// Top level of the LZ78 factor encoder: input and output channels, match state, cell row.
// The encoder takes one byte per transfer and, for each byte that ends a factor or the stream,
// delivers one factor (symbol, prefix index, stream-done flag). For each byte, every dictionary
// cell first compares its entry with the pair of current match index and byte in parallel and
// registers its hit; then, once the output slot is free, the hit index is gathered along the
// cell row and fed back as the new match index, and a new entry is written on a miss. A new
// byte is taken only as the current one completes, and that waits on the output side taking
// the previous factor. Dictionary entries start undefined and only entries below the next
// free index are ever matched; the final byte of a stream returns the dictionary to empty at
// once, with no clearing pass. When the dictionary is full, no further entries are added.
module lz78_encoder
  import lz78_pkg::*;
#(
  parameter int DICT_SIZE = DICT_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lz78_in_if.sink    in_ch,
  lz78_out_if.source out_ch
);

  localparam int IDX_W = (DICT_SIZE > 1) ? $clog2(DICT_SIZE) : 1;
  localparam int NF_W  = $clog2(DICT_SIZE + 1);

  logic             busy;
  logic             phase;
  logic [SYM_W-1:0] item_byte;
  logic             item_last;
  logic [IDX_W-1:0] match_index;
  logic [NF_W-1:0]  next_free_index;

  logic             out_valid;
  logic [SYM_W-1:0] out_symbol;
  logic [PREFIX_W-1:0] out_prefix;
  logic             out_done;

  logic             slot_free;
  logic             fire;
  logic             accept;
  logic             hit;
  logic [IDX_W-1:0] hit_index;
  logic [PREFIX_W-1:0] prefix_ext;
  cell_cmd_t        cmd;

  logic [IDX_W-1:0] chain [DICT_SIZE];

  assign slot_free = !out_valid || out_ch.ready;
  assign fire      = busy && phase && slot_free;
  assign in_ch.ready = !busy || fire;
  assign accept    = in_ch.valid && in_ch.ready;

  assign hit_index = chain[DICT_SIZE-1];
  assign hit       = hit_index != '0;

  assign cmd.compare = busy && !phase;
  assign cmd.write   = fire && !hit;

  assign chain[0] = '0;

  for (genvar k = 1; k < DICT_SIZE; k++) begin : g_cell
    lz78_cell #(
      .IDX_W   (IDX_W),
      .NF_W    (NF_W),
      .CellIdx (k)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .cmd           (cmd),
      .key_parent    (match_index),
      .key_byte      (item_byte),
      .next_free     (next_free_index),
      .hit_chain_in  (chain[k-1]),
      .hit_chain_out (chain[k])
    );
  end

  if (IDX_W >= PREFIX_W) begin : g_prefix_trunc
    assign prefix_ext = match_index[PREFIX_W-1:0];
  end else begin : g_prefix_ext
    assign prefix_ext = {{(PREFIX_W-IDX_W){1'b0}}, match_index};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (accept) begin
      busy  <= 1'b1;
      phase <= 1'b0;
    end else if (fire) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (busy) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_byte <= in_ch.data_byte;
      item_last <= in_ch.end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_index     <= '0;
      next_free_index <= NF_W'(1);
    end else if (fire) begin
      if (item_last) begin
        match_index     <= '0;
        next_free_index <= NF_W'(1);
      end else if (hit) begin
        match_index <= hit_index;
      end else begin
        match_index <= '0;
        if (next_free_index < NF_W'(DICT_SIZE)) begin
          next_free_index <= next_free_index + NF_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && (!hit || item_last)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (!hit || item_last)) begin
      out_symbol <= item_byte;
      out_prefix <= prefix_ext;
      out_done   <= item_last;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.symbol       = out_symbol;
  assign out_ch.prefix_index = out_prefix;
  assign out_ch.stream_done  = out_done;

endmodule
